// File: src/digraph_square_cipher_assert.svh
// Assertion macros for the checker file of the digraph square cipher.
`ifndef DIGRAPH_SQUARE_CIPHER_ASSERT_SVH
`define DIGRAPH_SQUARE_CIPHER_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define DSC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also looks at cycles in and around reset.
`define DSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/dsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_pkg
// Types, constants and coordinate helpers for the digraph square cipher.
// ----------------------------------------------------------------------------
package dsc_pkg;

  localparam int SYM_W           = 8;
  localparam int COORD_W         = 4;
  localparam int SQUARE_SIDE_DEF = 16;
  localparam logic [SYM_W-1:0] PAD_SYMBOL = '0;

  typedef enum logic {
    CMD_KEY  = 1'b0,
    CMD_DATA = 1'b1
  } cmd_t;

  // One key square write: cell and symbol.
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] idx;
    logic [SYM_W-1:0] val;
  } key_wr_t;

  // Paired read request on one memory.
  typedef struct packed {
    logic             en;
    logic [SYM_W-1:0] addr_a;
    logic [SYM_W-1:0] addr_b;
  } rd_req_t;

  // True when a coordinate lies inside a square of the given side.
  function automatic logic coord_ok(input logic [COORD_W-1:0] c, input int side);
    coord_ok = ({1'b0, c} < (COORD_W+1)'(side));
  endfunction

  // Neighbouring coordinate, wrapping round the square.
  function automatic logic [COORD_W-1:0] step_coord(input logic [COORD_W-1:0] c,
                                                    input logic back,
                                                    input int side);
    logic [COORD_W:0] up;
    up = {1'b0, c} + 1'b1;
    if (back) begin
      step_coord = (c == '0) ? COORD_W'(side - 1) : c - 1'b1;
    end else begin
      step_coord = (up >= (COORD_W+1)'(side)) ? '0 : up[COORD_W-1:0];
    end
  endfunction

endpackage

// File: src/dsc_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_square
// Key square and inverse position table, each a synchronous memory with one
// write port and two registered read ports.
// ----------------------------------------------------------------------------
module dsc_square
  import dsc_pkg::*;
(
  input  logic             clk,
  input  key_wr_t          key_wr,
  input  rd_req_t          pos_rd,
  input  rd_req_t          cell_rd,
  output logic [SYM_W-1:0] pos_a,
  output logic [SYM_W-1:0] pos_b,
  output logic [SYM_W-1:0] cell_a,
  output logic [SYM_W-1:0] cell_b
);

  localparam int DEPTH = 1 << SYM_W;

  logic [SYM_W-1:0] key_square      [DEPTH];
  logic [SYM_W-1:0] symbol_position [DEPTH];

  // A read on the same edge as a write returns the old entry.
  always_ff @(posedge clk) begin
    if (key_wr.en) begin
      key_square[key_wr.idx] <= key_wr.val;
    end
    if (cell_rd.en) begin
      cell_a <= key_square[cell_rd.addr_a];
      cell_b <= key_square[cell_rd.addr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (key_wr.en) begin
      symbol_position[key_wr.val] <= key_wr.idx;
    end
    if (pos_rd.en) begin
      pos_a <= symbol_position[pos_rd.addr_a];
      pos_b <= symbol_position[pos_rd.addr_b];
    end
  end

endmodule

// File: src/digraph_square_cipher.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digraph_square_cipher
// Playfair-style digraph cipher over a square of byte symbols.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// input     in_valid / in_ready   cmd, key_index, key_value, data_byte, last_in
// output    out_valid / out_ready out_byte, pair_end, message_end
// config    cfg_we                cfg_wdata (decrypt_mode)
//
// One input transfer per cycle while in_ready is high. A pair's first result
// appears once the transfer that completes it has passed the position read
// and then the key square read; the second follows when the first is taken.
// Reset clears the control state only; the key square must be loaded first.
// A stalled output holds both pipeline stages and stops input once s1 is full.
// ----------------------------------------------------------------------------
module digraph_square_cipher
  import dsc_pkg::*;
#(
  parameter int SQUARE_SIDE = SQUARE_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic             cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             cmd,
  input  logic [SYM_W-1:0] key_index,
  input  logic [SYM_W-1:0] key_value,
  input  logic [SYM_W-1:0] data_byte,
  input  logic             last_in,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [SYM_W-1:0] out_byte,
  output logic             pair_end,
  output logic             message_end
);

  logic             decrypt_mode;
  logic             holding;
  logic [SYM_W-1:0] held;

  logic             s1_valid;
  logic [SYM_W-1:0] s1_a;
  logic [SYM_W-1:0] s1_b;
  logic             s1_last;

  logic             s2_valid;
  logic             s2_phase;
  logic             s2_same;
  logic [SYM_W-1:0] s2_a;
  logic [SYM_W-1:0] s2_b;
  logic             s2_last;

  logic             in_xfer;
  logic             data_xfer;
  logic             pair_go;
  logic             hold_go;
  logic             s2_take;
  logic             s1_adv;
  logic             out_xfer;

  key_wr_t          key_wr;
  rd_req_t          pos_rd;
  rd_req_t          cell_rd;
  logic [SYM_W-1:0] pos_a;
  logic [SYM_W-1:0] pos_b;
  logic [SYM_W-1:0] cell_a;
  logic [SYM_W-1:0] cell_b;

  logic [COORD_W-1:0] a_row, a_col, b_row, b_col;
  logic               same_cell;

  assign s2_take   = !s2_valid || (s2_phase && out_ready);
  assign s1_adv    = s1_valid && s2_take;
  assign in_ready  = !s1_valid || s2_take;
  assign in_xfer   = in_valid && in_ready;
  assign data_xfer = in_xfer && (cmd == CMD_DATA);
  assign pair_go   = data_xfer && (holding || last_in);
  assign hold_go   = data_xfer && !holding && !last_in;
  assign out_xfer  = out_valid && out_ready;

  // Key writes outside the square are dropped.
  always_comb begin
    key_wr.en  = in_xfer && (cmd == CMD_KEY)
                 && coord_ok(key_index[SYM_W-1:COORD_W], SQUARE_SIDE)
                 && coord_ok(key_index[COORD_W-1:0], SQUARE_SIDE);
    key_wr.idx = key_index;
    key_wr.val = key_value;
  end

  always_comb begin
    pos_rd.en     = pair_go;
    pos_rd.addr_a = holding ? held : data_byte;
    pos_rd.addr_b = holding ? data_byte : PAD_SYMBOL;
  end

  always_comb begin
    a_row     = pos_a[SYM_W-1:COORD_W];
    a_col     = pos_a[COORD_W-1:0];
    b_row     = pos_b[SYM_W-1:COORD_W];
    b_col     = pos_b[COORD_W-1:0];
    same_cell = (pos_a == pos_b);

    cell_rd.en = s1_adv;
    if (a_row == b_row) begin
      cell_rd.addr_a = {a_row, step_coord(a_col, decrypt_mode, SQUARE_SIDE)};
      cell_rd.addr_b = {b_row, step_coord(b_col, decrypt_mode, SQUARE_SIDE)};
    end else if (a_col == b_col) begin
      cell_rd.addr_a = {step_coord(a_row, decrypt_mode, SQUARE_SIDE), a_col};
      cell_rd.addr_b = {step_coord(b_row, decrypt_mode, SQUARE_SIDE), b_col};
    end else begin
      cell_rd.addr_a = {b_row, a_col};
      cell_rd.addr_b = {a_row, b_col};
    end
  end

  dsc_square u_square (
    .clk     (clk),
    .key_wr  (key_wr),
    .pos_rd  (pos_rd),
    .cell_rd (cell_rd),
    .pos_a   (pos_a),
    .pos_b   (pos_b),
    .cell_a  (cell_a),
    .cell_b  (cell_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      decrypt_mode <= 1'b0;
      holding      <= 1'b0;
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      s2_phase     <= 1'b0;
    end else begin
      if (cfg_we) begin
        decrypt_mode <= cfg_wdata;
      end

      if (hold_go) begin
        holding <= 1'b1;
      end else if (pair_go) begin
        holding <= 1'b0;
      end

      if (pair_go) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end

      // Load a new pair, or advance through its two bytes.
      if (s1_adv) begin
        s2_valid <= 1'b1;
        s2_phase <= 1'b0;
      end else if (out_xfer) begin
        if (s2_phase) begin
          s2_valid <= 1'b0;
        end else begin
          s2_phase <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hold_go) begin
      held <= data_byte;
    end
    if (pair_go) begin
      s1_a    <= pos_rd.addr_a;
      s1_b    <= pos_rd.addr_b;
      s1_last <= last_in;
    end
    if (s1_adv) begin
      s2_same <= same_cell;
      s2_a    <= s1_a;
      s2_b    <= s1_b;
      s2_last <= s1_last;
    end
  end

  assign out_valid   = s2_valid;
  assign pair_end    = s2_phase;
  assign message_end = s2_phase && s2_last;

  always_comb begin
    if (s2_same) begin
      out_byte = s2_phase ? s2_b : s2_a;
    end else begin
      out_byte = s2_phase ? cell_b : cell_a;
    end
  end

endmodule

// File: src/dsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsc_checker
// Port-level checks on the output sequence and post-reset handshake state of the digraph square cipher.
// ----------------------------------------------------------------------------
`include "digraph_square_cipher_assert.svh"

module dsc_checker (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic pair_end,
  input logic message_end
);

  `DSC_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "output dropped while stalled")
  `DSC_ASSERT(a_pair_second, clk, rst, out_valid && out_ready && !pair_end |=> out_valid && pair_end, "second byte of pair not ready")
  `DSC_ASSERT(a_end_on_second, clk, rst, out_valid && message_end |-> pair_end, "message end on first byte")
  `DSC_ASSERT_ALWAYS(a_reset_clean, clk, $fell(rst) |-> !out_valid && in_ready, "pipeline not empty after reset")

endmodule

bind digraph_square_cipher dsc_checker u_dsc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .pair_end    (pair_end),
  .message_end (message_end)
);
